// File: design/eplg_pkg.sv
// Shared types and constants for the entropy pool random byte generator.
// No dependencies; imported by every design module.
package eplg_pkg;

    // Item operation codes
    typedef enum logic {
        OP_MIX      = 1'b0,
        OP_GENERATE = 1'b1
    } t_opcode;

    localparam int unsigned STATE_W  = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 4;
    localparam int unsigned FB_BIT   = 31;

    localparam logic [STATE_W-1:0] GEN_SEED  = 64'h0000_0000_0000_ACE1;
    localparam logic [STATE_W-1:0] POOL_BASE = 64'h0000_0000_5A5A_5A5A;
    localparam logic [STATE_W-1:0] POOL_STEP = 64'h0000_0000_1357_9BDF;

    // Reset value of pool word i (constant index, used on pool reset)
    function automatic logic [STATE_W-1:0] pool_init(input int unsigned idx);
        logic [STATE_W-1:0] prod;
        prod = STATE_W'(idx) * POOL_STEP;
        return POOL_BASE ^ prod;
    endfunction

endpackage

// File: design/entropy_pool_lfsr_generator.sv
// Entropy pool random byte generator, top level.
// Stages: input register, result register; the pool select and state XOR loop is combinational.
// Throughput: one transaction per cycle unless a generate meets a stalled result register.
// Mix transactions give no result and never wait on the output side.
// Synchronous active-low reset loads the seed state, the pool seeds and index zero.
// Depends on eplg_pkg, eplg_pool and eplg_stir.
module entropy_pool_lfsr_generator #(
    parameter int unsigned POOL_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_mix_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_random_byte,
    output logic [63:0] o_state_word
);
    import eplg_pkg::*;

    localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    logic               r_in_valid;
    t_opcode            r_in_op;
    logic [STATE_W-1:0] r_in_val;
    logic               r_out_valid;
    logic [STATE_W-1:0] r_out_state;
    logic [STATE_W-1:0] r_gen_state;
    logic [IDX_W-1:0]   r_pool_index;

    logic               w_out_free;
    logic               w_fire;
    logic               w_is_gen;
    logic               w_in_take;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [STATE_W-1:0] w_rd_data;
    logic [STATE_W-1:0] n_gen_state;
    logic [IDX_W-1:0]   n_pool_index;

    // Handshake: a held transaction fires when it needs no result slot or one is free
    assign w_is_gen   = (r_in_op == OP_GENERATE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fire     = r_in_valid && (!w_is_gen || w_out_free);
    assign o_stall    = r_in_valid && !w_fire;
    assign w_in_take  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op  <= t_opcode'(i_opcode);
            r_in_val <= i_mix_value;
        end
    end

    // Pool storage; mix transactions fold their value into the current entry
    eplg_pool #(
        .POOL_DEPTH (POOL_DEPTH),
        .IDX_W      (IDX_W)
    ) u_pool (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_fire && !w_is_gen),
        .i_wr_addr (r_pool_index),
        .i_wr_xor  (r_in_val),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    eplg_stir #(
        .POOL_DEPTH (POOL_DEPTH),
        .IDX_W      (IDX_W)
    ) u_stir (
        .i_op      (r_in_op),
        .i_state   (r_gen_state),
        .i_index   (r_pool_index),
        .i_rd_data (w_rd_data),
        .o_rd_addr (w_rd_addr),
        .o_state   (n_gen_state),
        .o_index   (n_pool_index)
    );

    // Generator state and pool index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_state  <= GEN_SEED;
            r_pool_index <= '0;
        end else if (w_fire) begin
            r_gen_state  <= n_gen_state;
            r_pool_index <= n_pool_index;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_is_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_gen) begin
            r_out_state <= n_gen_state;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_state_word  = r_out_state;
    assign o_random_byte = r_out_state[BYTE_W-1:0];

    // A fired generate transaction always shows up as a result next cycle
    a_gen_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_is_gen |=> o_valid)
        else $error("generate transaction did not produce a result");

    // A mix transaction leaves the result register untouched
    a_mix_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_is_gen |=> $stable(r_out_state))
        else $error("mix transaction changed the result register");

    // Pool index stays within the pool
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pool_index) < POOL_DEPTH)
        else $error("pool index out of range");

    // Nothing fires while a generate waits on a stalled, full result register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall && r_in_valid && w_is_gen |-> !w_fire)
        else $error("result overwritten while stalled");

endmodule

// File: design/eplg_pool.sv
// Entropy pool storage: one flop word per entry, in-place XOR update, one read port.
// Depends on eplg_pkg.
module eplg_pool #(
    parameter int unsigned POOL_DEPTH = 16,
    parameter int unsigned IDX_W      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [IDX_W-1:0]             i_wr_addr,
    input  logic [eplg_pkg::STATE_W-1:0] i_wr_xor,
    input  logic [IDX_W-1:0]             i_rd_addr,
    output logic [eplg_pkg::STATE_W-1:0] o_rd_data
);
    import eplg_pkg::*;

    logic [STATE_W-1:0] r_pool [POOL_DEPTH];

    // Fold the entropy word into the addressed entry; reload seeds on reset
    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_word
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pool[g] <= pool_init(g);
            end else if (i_wr_en && (i_wr_addr == IDX_W'(g))) begin
                r_pool[g] <= r_pool[g] ^ i_wr_xor;
            end
        end
    end

    // Select the requested word
    assign o_rd_data = r_pool[i_rd_addr];

endmodule

// File: design/eplg_stir.sv
// Next-state logic: shift-register step, pool index advance and pool word select.
// Depends on eplg_pkg; reads the pool through eplg_pool's read port.
module eplg_stir #(
    parameter int unsigned POOL_DEPTH = 16,
    parameter int unsigned IDX_W      = 4
) (
    input  eplg_pkg::t_opcode            i_op,
    input  logic [eplg_pkg::STATE_W-1:0] i_state,
    input  logic [IDX_W-1:0]             i_index,
    input  logic [eplg_pkg::STATE_W-1:0] i_rd_data,
    output logic [IDX_W-1:0]             o_rd_addr,
    output logic [eplg_pkg::STATE_W-1:0] o_state,
    output logic [IDX_W-1:0]             o_index
);
    import eplg_pkg::*;

    localparam int unsigned NUM_OFFSETS = 1 << OFFSET_W;

    logic [IDX_W-1:0]   c_off_mod [NUM_OFFSETS];
    logic [IDX_W-1:0]   w_index_inc;
    logic               w_fb;
    logic [STATE_W-1:0] w_shifted;
    logic [IDX_W:0]     w_sel_sum;
    logic [IDX_W-1:0]   w_sel;

    // Offsets 0..15 reduced modulo the pool depth (constant table)
    for (genvar g = 0; g < NUM_OFFSETS; g++) begin : g_off
        assign c_off_mod[g] = IDX_W'(g % POOL_DEPTH);
    end

    // Advance the index with wrap at the pool depth
    assign w_index_inc = (i_index == IDX_W'(POOL_DEPTH - 1)) ? '0 : i_index + IDX_W'(1);

    // Shift right by one, feedback joins at bit 31
    assign w_fb = i_state[0] ^ i_state[2] ^ i_state[3] ^ i_state[5];
    always_comb begin
        w_shifted         = i_state >> 1;
        w_shifted[FB_BIT] = i_state[FB_BIT+1] | w_fb;
    end

    // Pool select: index plus low state nibble, modulo depth
    assign w_sel_sum = {1'b0, i_index} + {1'b0, c_off_mod[w_shifted[OFFSET_W-1:0]]};
    assign w_sel     = (w_sel_sum >= (IDX_W+1)'(POOL_DEPTH))
                       ? IDX_W'(w_sel_sum - (IDX_W+1)'(POOL_DEPTH))
                       : w_sel_sum[IDX_W-1:0];

    // Mix stirs with the next entry; generate stirs with the selected entry
    always_comb begin
        case (i_op)
            OP_MIX: begin
                o_rd_addr = w_index_inc;
                o_state   = i_state ^ i_rd_data;
                o_index   = w_index_inc;
            end
            default: begin
                o_rd_addr = w_sel;
                o_state   = w_shifted ^ i_rd_data;
                o_index   = i_index;
            end
        endcase
    end

endmodule

// File: bench/entropy_pool_lfsr_generator_tb.sv
// Self-checking bench for entropy_pool_lfsr_generator: directed and random mix/generate traffic.
// Holds its own model of the generator state, pool and index, and checks every random byte.
// Depends on eplg_pkg and the design top level.
`timescale 1ns / 100ps

module entropy_pool_lfsr_generator_tb;
    import eplg_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned IDLE_PCT    = 24;
    localparam int unsigned CALM_FROM   = 600;
    localparam int unsigned CALM_TO     = 950;
    localparam int unsigned HOLD_AT     = 250;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned QUIET_LIMIT = 2000;

    typedef struct packed {
        t_opcode     op;
        logic [63:0] value;
    } t_pool_item;

    typedef struct packed {
        logic [7:0]  rnd_byte;
        logic [63:0] state;
    } t_draw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic [63:0] i_mix_value;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_random_byte;
    logic [63:0] o_state_word;

    // Shadow copy of the generator
    logic [63:0] gen_state;
    logic [63:0] pool_words [DEPTH];
    logic [3:0]  pool_ptr;

    t_pool_item pending_items [$];
    t_draw      expected_draws [$];

    int unsigned cyc;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    int unsigned mix_count;
    int unsigned gen_count;
    int unsigned draws_checked;
    int unsigned index_wraps;
    int unsigned errors;

    entropy_pool_lfsr_generator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_mix_value  (i_mix_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_random_byte(o_random_byte),
        .o_state_word (o_state_word)
    );

    // Load seed state, seeded pool and index zero
    function void seed_generator();
        gen_state = GEN_SEED;
        for (int i = 0; i < DEPTH; i++) begin
            pool_words[i] = POOL_BASE ^ (64'(i) * POOL_STEP);
        end
        pool_ptr = '0;
    endfunction

    // Advance the shadow generator by one transaction; queue the draw it yields
    function void stir_generator(t_pool_item it);
        logic       fb;
        logic [3:0] sel;
        t_draw      d;
        if (it.op == OP_MIX) begin
            pool_words[pool_ptr] = pool_words[pool_ptr] ^ it.value;
            if (pool_ptr == 4'(DEPTH - 1)) index_wraps++;
            pool_ptr  = 4'((pool_ptr + 1) % DEPTH);
            gen_state = gen_state ^ pool_words[pool_ptr];
            mix_count++;
        end else begin
            fb        = gen_state[0] ^ gen_state[2] ^ gen_state[3] ^ gen_state[5];
            gen_state = (gen_state >> 1) | (64'(fb) << FB_BIT);
            // offset is the low four state bits; the sum wraps at the pool depth
            sel       = 4'((pool_ptr + gen_state[3:0]) % DEPTH);
            gen_state = gen_state ^ pool_words[sel];
            d.rnd_byte = gen_state[7:0];
            d.state    = gen_state;
            expected_draws.push_back(d);
            gen_count++;
        end
    endfunction

    function t_pool_item make_item(t_opcode op, logic [63:0] value);
        t_pool_item it;
        it.op    = op;
        it.value = value;
        return it;
    endfunction

    // Random entropy word, biased toward extremes now and then
    function logic [63:0] random_word();
        logic [63:0] w;
        int unsigned pick;
        pick = $urandom_range(15);
        case (pick)
            0: w = '0;
            1: w = '1;
            2: w = 64'(1) << $urandom_range(63);
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function logic calm_window();
        return (cyc >= CALM_FROM) && (cyc < CALM_TO);
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Sender: present queued transactions, idle at random, hold payload while stalled
    always @(posedge i_clk) begin : p_drive
        t_pool_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                stir_generator(make_item(t_opcode'(i_opcode), i_mix_value));
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 &&
                    (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_opcode    <= nxt.op;
                    i_mix_value <= nxt.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each draw against the oldest expectation, then choose next stall
    always @(posedge i_clk) begin : p_check
        t_draw want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_draws.size() == 0) begin
                    $display("%0t: unexpected draw byte %h state %h",
                             $time, o_random_byte, o_state_word);
                    errors++;
                end else begin
                    want = expected_draws.pop_front();
                    draws_checked++;
                    if (o_random_byte !== want.rnd_byte) begin
                        $display("%0t: random_byte expected %h actual %h",
                                 $time, want.rnd_byte, o_random_byte);
                        errors++;
                    end
                    if (o_state_word !== want.state) begin
                        $display("%0t: state_word expected %h actual %h",
                                 $time, want.state, o_state_word);
                        errors++;
                    end
                end
            end
            // long hold-off so the block backs up and stalls its input
            if (cyc == HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm_window() && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cyc           = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        mix_count     = 0;
        gen_count     = 0;
        draws_checked = 0;
        index_wraps   = 0;
        errors        = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_MIX;
        i_mix_value   = '0;
        i_stall       = 1'b0;
        seed_generator();

        // Directed: draws from the seed, extreme words, ignored value on generate
        pending_items.push_back(make_item(OP_GENERATE, '0));
        pending_items.push_back(make_item(OP_GENERATE, '1));
        pending_items.push_back(make_item(OP_MIX, '0));
        pending_items.push_back(make_item(OP_GENERATE, '0));
        pending_items.push_back(make_item(OP_MIX, '1));
        pending_items.push_back(make_item(OP_GENERATE, '0));
        pending_items.push_back(make_item(OP_MIX, 64'hAAAA_AAAA_AAAA_AAAA));
        pending_items.push_back(make_item(OP_MIX, 64'h5555_5555_5555_5555));
        pending_items.push_back(make_item(OP_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA));
        pending_items.push_back(make_item(OP_MIX, 64'h8000_0000_0000_0000));
        pending_items.push_back(make_item(OP_MIX, 64'h0000_0000_8000_0000));
        pending_items.push_back(make_item(OP_MIX, 64'h0000_0000_0000_0001));
        // back-to-back draws exercise the feedback at bit 31 and the wrapped select
        for (int i = 0; i < 6; i++) pending_items.push_back(make_item(OP_GENERATE, '0));
        for (int i = 0; i < 4; i++) pending_items.push_back(make_item(OP_MIX, '1));
        pending_items.push_back(make_item(OP_GENERATE, 64'h5555_5555_5555_5555));
        pending_items.push_back(make_item(OP_GENERATE, '1));

        // Random traffic: mixed opcodes, random entropy words
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_items.push_back(make_item(t_opcode'($urandom_range(1)), random_word()));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all sent, all draws returned, then let the pipeline settle
        while (pending_items.size() != 0 || i_valid || expected_draws.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d mix and %0d generate transactions; %0d draws checked, %0d index wraps.",
                 mix_count, gen_count, draws_checked, index_wraps);
        if (errors == 0 && expected_draws.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
design/eplg_pkg.sv
design/eplg_pool.sv
design/eplg_stir.sv
design/entropy_pool_lfsr_generator.sv
bench/entropy_pool_lfsr_generator_tb.sv
